// ===== hw/rtl/firq15_pkg.sv =====
`default_nettype none

package firq15_pkg;

    localparam int MAX_TAPS = 32;
    localparam int Q_SHIFT  = 15;
    localparam int DATA_W   = 16;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int TAP_W    = 5;
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);

    localparam logic             FUNC_WRITE      = 1'b0;
    localparam logic             FUNC_PUSH       = 1'b1;
    localparam logic [CNT_W-1:0] TAP_COUNT_RESET = CNT_W'(MAX_TAPS);

    typedef logic signed [DATA_W-1:0] sample_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic shift;
        logic rotate;
        logic write;
    } cell_ctrl_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/firq15_cell.sv =====
`default_nettype none

module firq15_cell (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire firq15_pkg::cell_ctrl_t ctrl,
    input  wire firq15_pkg::sample_t    shift_in,
    input  wire firq15_pkg::sample_t    rot_d,
    input  wire firq15_pkg::sample_t    rot_c,
    input  wire firq15_pkg::sample_t    wr_coef,
    output firq15_pkg::sample_t         d,
    output firq15_pkg::sample_t         c
);

    firq15_pkg::sample_t d_reg;
    firq15_pkg::sample_t c_reg;

    // delay tap: aged by a push, circulated during the mac pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else
        begin
            priority if (ctrl.shift)
            begin
                d_reg <= shift_in;
            end
            else if (ctrl.rotate)
            begin
                d_reg <= rot_d;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (ctrl.write)
        begin
            c_reg <= wr_coef;
        end
        else if (ctrl.rotate)
        begin
            c_reg <= rot_c;
        end
    end

    assign d = d_reg;
    assign c = c_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/firq15_mac.sv =====
`default_nettype none

module firq15_mac (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire firq15_pkg::mac_ctrl_t     ctrl,
    input  wire firq15_pkg::sample_t       d,
    input  wire firq15_pkg::sample_t       c,
    output logic [firq15_pkg::DATA_W-1:0]  acc
);

    logic signed [firq15_pkg::PROD_W-1:0] prod_next;
    logic signed [firq15_pkg::PROD_W-1:0] prod_reg;
    logic                                 prod_vld_reg;
    logic [firq15_pkg::DATA_W-1:0]        acc_reg;
    logic [firq15_pkg::DATA_W-1:0]        acc_next;

    assign prod_next = firq15_pkg::PROD_W'(d) * firq15_pkg::PROD_W'(c);

    // asr by 15 then keep 16 bits: only this slice reaches the wrapped sum
    assign acc_next = acc_reg
        + prod_reg[firq15_pkg::Q_SHIFT + firq15_pkg::DATA_W - 1 : firq15_pkg::Q_SHIFT];

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fir_filter_q15_direct_form_top.sv =====
// channel | signals                                     | transfer when
// --------+---------------------------------------------+-----------------------
// in      | in_valid in_ready func tap_index            | in_valid & in_ready
//         | coefficient sample                          |
// out     | out_valid out_ready filtered                | out_valid & out_ready
// cfg     | cfg_valid cfg_ready cfg_data (tap_count)    | cfg_valid & cfg_ready
//
// a coefficient write completes in ST_IDLE; a sample push runs ST_MAC over the
// n taps in use, with the single multiplier fed from tap cell 0 while the tap
// ring circulates once, then ST_DRAIN and ST_DONE. the result sits in an output
// register, so a new item is taken while it waits; a finished sum waits only if
// that register is still full. reset clears the delay line, sets tap_count to 32.

`default_nettype none

module fir_filter_q15_direct_form_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                func,
    input  wire logic [firq15_pkg::TAP_W-1:0]        tap_index,
    input  wire logic signed [firq15_pkg::DATA_W-1:0] coefficient,
    input  wire logic signed [firq15_pkg::DATA_W-1:0] sample,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [firq15_pkg::DATA_W-1:0]     filtered,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [firq15_pkg::CNT_W-1:0]        cfg_data
);

    firq15_pkg::state_t state_reg;
    firq15_pkg::state_t state_next;

    logic [firq15_pkg::CNT_W-1:0]  tap_count_reg;
    logic [firq15_pkg::CNT_W-1:0]  n_act;
    logic [firq15_pkg::CNT_W-1:0]  n_reg;
    logic [firq15_pkg::CNT_W-1:0]  cnt_reg;
    logic                          out_valid_reg;
    logic [firq15_pkg::DATA_W-1:0] filtered_reg;
    logic [firq15_pkg::DATA_W-1:0] acc;

    logic push_fire;
    logic wr_fire;
    logic rot_en;
    logic out_load;
    logic last_tap;

    firq15_pkg::sample_t d_arr [firq15_pkg::MAX_TAPS];
    firq15_pkg::sample_t c_arr [firq15_pkg::MAX_TAPS];
    firq15_pkg::mac_ctrl_t mac_ctrl;

    // zero counts as one tap, anything above the line length saturates
    always_comb
    begin
        priority if (tap_count_reg == '0)
        begin
            n_act = firq15_pkg::CNT_W'(1);
        end
        else if (tap_count_reg > firq15_pkg::CNT_W'(firq15_pkg::MAX_TAPS))
        begin
            n_act = firq15_pkg::CNT_W'(firq15_pkg::MAX_TAPS);
        end
        else
        begin
            n_act = tap_count_reg;
        end
    end

    assign push_fire = in_valid && in_ready && (func == firq15_pkg::FUNC_PUSH);
    assign wr_fire   = in_valid && in_ready && (func == firq15_pkg::FUNC_WRITE);
    assign last_tap  = (cnt_reg == (n_reg - firq15_pkg::CNT_W'(1)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            firq15_pkg::ST_IDLE:
            begin
                if (push_fire)
                begin
                    state_next = firq15_pkg::ST_MAC;
                end
            end
            firq15_pkg::ST_MAC:
            begin
                if (last_tap)
                begin
                    state_next = firq15_pkg::ST_DRAIN;
                end
            end
            firq15_pkg::ST_DRAIN:
            begin
                state_next = firq15_pkg::ST_DONE;
            end
            firq15_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = firq15_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = firq15_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        rot_en   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            firq15_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            firq15_pkg::ST_MAC:
            begin
                rot_en = 1'b1;
            end
            firq15_pkg::ST_DRAIN:
            begin
                rot_en = 1'b0;
            end
            firq15_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= firq15_pkg::ST_IDLE;
            tap_count_reg <= firq15_pkg::TAP_COUNT_RESET;
            n_reg         <= firq15_pkg::CNT_W'(1);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                tap_count_reg <= cfg_data;
            end
            if (push_fire)
            begin
                n_reg   <= n_act;
                cnt_reg <= '0;
            end
            else if (rot_en)
            begin
                cnt_reg <= cnt_reg + firq15_pkg::CNT_W'(1);
            end
            priority if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            filtered_reg <= acc;
        end
    end

    // tap ring: a push ages the used taps, the mac pass turns them once around
    // so that cell 0 shows tap k after k steps and the ring ends where it began
    for (genvar i = 0; i < firq15_pkg::MAX_TAPS; i++)
    begin : g_tap
        firq15_pkg::cell_ctrl_t ctrl;
        firq15_pkg::sample_t    shift_in;
        firq15_pkg::sample_t    rot_d;
        firq15_pkg::sample_t    rot_c;

        assign ctrl.shift  = push_fire && (firq15_pkg::CNT_W'(i) < n_act);
        assign ctrl.rotate = rot_en && (firq15_pkg::CNT_W'(i) < n_reg);
        assign ctrl.write  = wr_fire && (tap_index == firq15_pkg::TAP_W'(i));

        if (i == 0)
        begin : g_head
            assign shift_in = sample;
        end
        else
        begin : g_body
            assign shift_in = d_arr[i-1];
        end

        if (i == firq15_pkg::MAX_TAPS - 1)
        begin : g_wrap
            assign rot_d = d_arr[0];
            assign rot_c = c_arr[0];
        end
        else
        begin : g_next
            assign rot_d = (n_reg == firq15_pkg::CNT_W'(i + 1)) ? d_arr[0] : d_arr[i+1];
            assign rot_c = (n_reg == firq15_pkg::CNT_W'(i + 1)) ? c_arr[0] : c_arr[i+1];
        end

        firq15_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .shift_in (shift_in),
            .rot_d    (rot_d),
            .rot_c    (rot_c),
            .wr_coef  (coefficient),
            .d        (d_arr[i]),
            .c        (c_arr[i])
        );
    end

    assign mac_ctrl.clear  = push_fire;
    assign mac_ctrl.mul_en = rot_en;

    firq15_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .d     (d_arr[0]),
        .c     (c_arr[0]),
        .acc   (acc)
    );

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/firq15_chk.sv =====
`default_nettype none

module firq15_chk (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic                                func,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic signed [firq15_pkg::DATA_W-1:0] filtered
);

    // a waiting result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered))
        else $error("result changed while stalled");

    // a coefficient write leaves the block ready the next cycle
    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == firq15_pkg::FUNC_WRITE) |=> in_ready)
        else $error("coefficient write did not complete in one cycle");

    // a push leaves the block busy as the mac pass starts and on the step after it
    a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == firq15_pkg::FUNC_PUSH) |=> !in_ready)
        else $error("input taken during mac pass");

    a_push_busy2: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == firq15_pkg::FUNC_PUSH) |=> ##1 !in_ready)
        else $error("input taken before drain");

endmodule

bind fir_filter_q15_direct_form_top firq15_chk u_firq15_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered)
);

`default_nettype wire
